// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LTA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define LTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/ltattr_pkg.sv =====
// types and constants of the last-touch attribution block
package ltattr_pkg;

  localparam logic [1:0] CMD_ROW   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] user_key;
    logic        trigger_flag;
    logic [15:0] trigger_value;
    logic [7:0]  campaign_id;
  } ltattr_in_t;

  typedef struct packed {
    logic        attributed;
    logic [7:0]  campaign;
    logic [31:0] total;
    logic        bad_campaign;
  } ltattr_out_t;

  typedef enum logic [2:0] {
    OP_ZERO,
    OP_SHOW,
    OP_CREDIT,
    OP_BAD,
    OP_CLEAR
  } ltattr_op_e;

  typedef struct packed {
    ltattr_op_e  op;
    logic [7:0]  camp;
    logic [15:0] value;
  } ltattr_op_t;

endpackage

// ===== hw/rtl/ltattr_ram.sv =====
// generic single-write ram with registered read
module ltattr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ltattr_front.sv =====
// run tracking and per-row decode into a counter operation
module ltattr_front #(
  parameter int CAMPAIGNS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  ltattr_pkg::ltattr_in_t in_row,
  output ltattr_pkg::ltattr_op_t op,
  output logic                 run_valid
);

  localparam logic [8:0] LIMIT = 9'(CAMPAIGNS);

  logic [31:0] run_key_r, run_key_nxt;
  logic        run_valid_r, run_valid_nxt;
  logic        seen_r, seen_nxt;
  logic [7:0]  src_r, src_nxt;
  logic        new_run, seen_now, id_bad, src_bad;

  assign new_run  = !run_valid_r || (in_row.user_key != run_key_r);
  assign seen_now = new_run ? 1'b0 : seen_r;
  assign id_bad   = {1'b0, in_row.campaign_id} >= LIMIT;
  assign src_bad  = {1'b0, src_r} >= LIMIT;

  always_comb begin
    op            = '{op: ltattr_pkg::OP_ZERO, camp: 8'd0, value: in_row.trigger_value};
    run_key_nxt   = run_key_r;
    run_valid_nxt = run_valid_r;
    seen_nxt      = seen_r;
    src_nxt       = src_r;
    case (in_row.command)
      ltattr_pkg::CMD_ROW: begin
        run_key_nxt   = in_row.user_key;
        run_valid_nxt = 1'b1;
        seen_nxt      = seen_now;
        if (!in_row.trigger_flag) begin
          // source row becomes the run's last touch
          seen_nxt = 1'b1;
          src_nxt  = in_row.campaign_id;
          op.camp  = in_row.campaign_id;
          op.op    = id_bad ? ltattr_pkg::OP_BAD : ltattr_pkg::OP_SHOW;
        end else if (seen_now) begin
          op.camp = src_r;
          op.op   = src_bad ? ltattr_pkg::OP_BAD : ltattr_pkg::OP_CREDIT;
        end
      end
      ltattr_pkg::CMD_READ: begin
        op.camp = in_row.campaign_id;
        op.op   = id_bad ? ltattr_pkg::OP_BAD : ltattr_pkg::OP_SHOW;
      end
      ltattr_pkg::CMD_CLEAR: begin
        op.op         = ltattr_pkg::OP_CLEAR;
        run_key_nxt   = 32'd0;
        run_valid_nxt = 1'b0;
        seen_nxt      = 1'b0;
        src_nxt       = 8'd0;
      end
      default: begin
        op.op = ltattr_pkg::OP_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_key_r   <= 32'd0;
      run_valid_r <= 1'b0;
      seen_r      <= 1'b0;
      src_r       <= 8'd0;
    end else if (accept) begin
      run_key_r   <= run_key_nxt;
      run_valid_r <= run_valid_nxt;
      seen_r      <= seen_nxt;
      src_r       <= src_nxt;
    end
  end

  assign run_valid = run_valid_r;

endmodule

// ===== hw/rtl/ltattr_acc.sv =====
// counter stage: valid bits, write forwarding, saturating add, result build
module ltattr_acc #(
  parameter int CAMPAIGNS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ltattr_pkg::ltattr_op_t    s1_op,
  input  logic                      s1_fire,
  input  logic [31:0]               ram_q,
  output logic                      wr_en,
  output logic [$clog2(CAMPAIGNS)-1:0] wr_addr,
  output logic [31:0]               wr_data,
  output ltattr_pkg::ltattr_out_t   result
);

  localparam int AW = $clog2(CAMPAIGNS);

  logic [CAMPAIGNS-1:0] vbits_r, vbits_nxt;
  logic                 fwd_valid_r;
  logic [AW-1:0]        fwd_addr_r;
  logic [31:0]          fwd_data_r;
  logic [AW-1:0]        addr;
  logic                 in_table;
  logic [31:0]          cur;
  logic [32:0]          sum;
  logic [31:0]          sat;

  assign addr     = s1_op.camp[AW-1:0];
  assign in_table = {1'b0, s1_op.camp} < 9'(CAMPAIGNS);

  // latest write wins over the ram copy, which was read at accept
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == addr)) begin
      cur = fwd_data_r;
    end else if (in_table && vbits_r[addr]) begin
      cur = ram_q;
    end else begin
      cur = 32'd0;
    end
  end

  assign sum = {1'b0, cur} + {17'd0, s1_op.value};
  assign sat = sum[32] ? ltattr_pkg::TOTAL_MAX : sum[31:0];

  always_comb begin
    result = '0;
    case (s1_op.op)
      ltattr_pkg::OP_SHOW: begin
        result.campaign = s1_op.camp;
        result.total    = cur;
      end
      ltattr_pkg::OP_CREDIT: begin
        result.attributed = 1'b1;
        result.campaign   = s1_op.camp;
        result.total      = sat;
      end
      ltattr_pkg::OP_BAD: begin
        result.campaign     = s1_op.camp;
        result.bad_campaign = 1'b1;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  assign wr_en   = s1_fire && (s1_op.op == ltattr_pkg::OP_CREDIT);
  assign wr_addr = addr;
  assign wr_data = sat;

  always_comb begin
    vbits_nxt = vbits_r;
    if (s1_fire && (s1_op.op == ltattr_pkg::OP_CLEAR)) begin
      vbits_nxt = '0;
    end else if (wr_en) begin
      vbits_nxt[addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbits_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      vbits_r <= vbits_nxt;
      if (s1_fire && (s1_op.op == ltattr_pkg::OP_CLEAR)) begin
        fwd_valid_r <= 1'b0;
      end else if (wr_en) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= addr;
      fwd_data_r <= sat;
    end
  end

endmodule

// ===== hw/rtl/last_touch_attribution_core.sv =====
// an accepted transaction passes through the operation register and the result register to out_data
// throughput: one transaction per cycle while the receiver does not stall; the counter ram is read at accept
//   and written as the operation fires, with a forwarding register covering the gap
// reset: rst_n low clears run tracking, counter valid bits and both stages;
//   every counter then reads as zero without a clearing pass
// top level of the last-touch attribution block
`include "assert_macros.svh"

module last_touch_attribution_core #(
  parameter int CAMPAIGNS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ltattr_pkg::ltattr_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ltattr_pkg::ltattr_out_t out_data
);

  localparam int AW = $clog2(CAMPAIGNS);

  // handshake
  logic accept, s1_adv, s1_fire;

  // decode stage
  ltattr_pkg::ltattr_op_t  front_op;
  logic                    run_valid;

  // operation register between decode and counter update
  logic                    s1_valid_r, s1_valid_nxt;
  ltattr_pkg::ltattr_op_t  s1_op_r;

  // counter ram
  logic [31:0]   ram_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  // result register
  ltattr_pkg::ltattr_out_t result;
  logic                    out_valid_r, out_valid_nxt;
  ltattr_pkg::ltattr_out_t out_r;

  // the operation stage moves whenever the result register is free or draining
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && s1_adv;

  // run tracking updates at accept so the next row sees it at once
  ltattr_front #(.CAMPAIGNS(CAMPAIGNS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_row   (in_data),
    .op       (front_op),
    .run_valid(run_valid)
  );

  // read address comes straight from decode; rdata holds while the stage stalls
  ltattr_ram #(.WIDTH(32), .DEPTH(CAMPAIGNS)) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (accept),
    .raddr(front_op.camp[AW-1:0]),
    .rdata(ram_q)
  );

  ltattr_acc #(.CAMPAIGNS(CAMPAIGNS)) u_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_op  (s1_op_r),
    .s1_fire(s1_fire),
    .ram_q  (ram_q),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .result (result)
  );

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r <= front_op;
    end
    if (s1_fire) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // input only stalls behind a held operation
  `LTA_ASSERT_NOW(a_stall_needs_s1, clk, rst_n, in_stall, s1_valid_r)
  // a credited transaction never carries the bad flag
  `LTA_ASSERT_NOW(a_attr_not_bad, clk, rst_n, out_valid_r && out_r.attributed,
    !out_r.bad_campaign)
  // an accepted clear drops run tracking
  `LTA_ASSERT_NEXT(a_clear_drops_run, clk, rst_n,
    accept && (in_data.command == ltattr_pkg::CMD_CLEAR), !run_valid)
  // counter writes only happen as a credit leaves for the result register
  `LTA_ASSERT_NEXT(a_write_gives_result, clk, rst_n, wr_en,
    out_valid_r && out_r.attributed)

endmodule

// ===== dv/ltattr_checker.sv =====
`timescale 1ns / 1ps
// checker for the last-touch attribution core: predicts each result and compares it
module ltattr_checker #(
  parameter int CAMPAIGNS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  ltattr_pkg::ltattr_in_t  in_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  ltattr_pkg::ltattr_out_t out_data,
  output int                      mismatches,
  output int                      pending
);

  logic [31:0] credit_totals [CAMPAIGNS];
  logic [31:0] run_key;
  logic        run_live;
  logic        has_source;
  logic [7:0]  source_id;

  ltattr_pkg::ltattr_out_t expected_results [$];

  function automatic ltattr_pkg::ltattr_out_t pack_result(logic attr, logic [7:0] camp,
                                                          logic [31:0] tot, logic bad);
    ltattr_pkg::ltattr_out_t r;
    r.attributed   = attr;
    r.campaign     = camp;
    r.total        = tot;
    r.bad_campaign = bad;
    return r;
  endfunction

  function automatic void clear_tracking();
    for (int i = 0; i < CAMPAIGNS; i++) credit_totals[i] = '0;
    run_key    = '0;
    run_live   = 1'b0;
    has_source = 1'b0;
    source_id  = '0;
  endfunction

  // last-touch crediting of one transaction, updates the tracked state
  function automatic ltattr_pkg::ltattr_out_t attribute_row(ltattr_pkg::ltattr_in_t t);
    logic [32:0] sum;
    ltattr_pkg::ltattr_out_t r;
    r = '0;
    case (t.command)
      ltattr_pkg::CMD_ROW: begin
        if (!run_live || t.user_key != run_key) begin
          run_key    = t.user_key;
          run_live   = 1'b1;
          has_source = 1'b0;
        end
        if (!t.trigger_flag) begin
          has_source = 1'b1;
          source_id  = t.campaign_id;
          if (t.campaign_id < CAMPAIGNS)
            r = pack_result(1'b0, t.campaign_id, credit_totals[t.campaign_id], 1'b0);
          else
            r = pack_result(1'b0, t.campaign_id, '0, 1'b1);
        end else if (has_source) begin
          if (source_id < CAMPAIGNS) begin
            sum = {1'b0, credit_totals[source_id]} + {17'd0, t.trigger_value};
            credit_totals[source_id] = sum[32] ? ltattr_pkg::TOTAL_MAX : sum[31:0];
            r = pack_result(1'b1, source_id, credit_totals[source_id], 1'b0);
          end else begin
            r = pack_result(1'b0, source_id, '0, 1'b1);
          end
        end
      end
      ltattr_pkg::CMD_READ: begin
        if (t.campaign_id < CAMPAIGNS)
          r = pack_result(1'b0, t.campaign_id, credit_totals[t.campaign_id], 1'b0);
        else
          r = pack_result(1'b0, t.campaign_id, '0, 1'b1);
      end
      ltattr_pkg::CMD_CLEAR: clear_tracking();
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ltattr_checker: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    ltattr_pkg::ltattr_out_t want;
    if (!rst_n) begin
      clear_tracking();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, total", out_data.total, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.attributed !== want.attributed)
            report_mismatch("attributed", 32'(out_data.attributed), 32'(want.attributed));
          if (out_data.campaign !== want.campaign)
            report_mismatch("campaign", 32'(out_data.campaign), 32'(want.campaign));
          if (out_data.total !== want.total)
            report_mismatch("total", out_data.total, want.total);
          if (out_data.bad_campaign !== want.bad_campaign)
            report_mismatch("bad_campaign", 32'(out_data.bad_campaign),
                            32'(want.bad_campaign));
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(attribute_row(in_data));
    end
    pending <= expected_results.size();
  end

endmodule

// ===== dv/tb_last_touch_attribution_core.sv =====
`timescale 1ns / 1ps
// testbench top for last_touch_attribution_core: stimulus, stall pattern and verdict
module tb_last_touch_attribution_core;

  localparam int CAMPAIGNS = 4;
  // command code the block leaves unused
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // cycles with no transaction on either channel before giving up
  localparam int IDLE_LIMIT = 2000;
  // max-value triggers sent back to back on one counter
  localparam int HEAVY_ROWS = 40;
  localparam int RANDOM_ROWS = 430;
  // pipeline is two deep, a few spare cycles catch stray results
  localparam int TAIL_CYCLES = 12;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  ltattr_pkg::ltattr_in_t  in_data;
  logic                    out_valid;
  logic                    out_stall;
  ltattr_pkg::ltattr_out_t out_data;

  int mismatches;
  int pending;
  int idle_cycles;
  int burst_left;
  bit steady_sender;

  last_touch_attribution_core #(
    .CAMPAIGNS(CAMPAIGNS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  ltattr_checker #(
    .CAMPAIGNS(CAMPAIGNS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stall: switches between free flow, light and heavy random stall
  // and a periodic pattern, each held for a random stretch
  initial begin : stall_gen
    int mode;
    int mode_left;
    out_stall <= 1'b0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 70);
        default: out_stall <= ((mode_left % 16) < 5);
      endcase
    end
  end

  // watchdog: a long stretch with no transaction on either side means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_last_touch_attribution_core: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic ltattr_pkg::ltattr_in_t make_row(logic [1:0] cmd, logic [31:0] key,
                                                      logic trig, logic [15:0] value,
                                                      logic [7:0] camp);
    ltattr_pkg::ltattr_in_t t;
    t.command       = cmd;
    t.user_key      = key;
    t.trigger_flag  = trig;
    t.trigger_value = value;
    t.campaign_id   = camp;
    return t;
  endfunction

  // one random transaction within the run of key: mostly report rows, with
  // reads, clears, the unused command and stray keys mixed in as noise
  function automatic ltattr_pkg::ltattr_in_t random_row(logic [31:0] key);
    ltattr_pkg::ltattr_in_t t;
    int roll;
    int vroll;
    roll  = $urandom_range(0, 99);
    vroll = $urandom_range(0, 9);
    t = make_row(ltattr_pkg::CMD_ROW, key, ($urandom_range(0, 99) < 55),
                 16'($urandom_range(0, 65535)), '0);
    // zero and max trigger values show up often
    if (vroll == 0) t.trigger_value = '0;
    else if (vroll == 1) t.trigger_value = 16'hFFFF;
    // mostly valid campaigns, some ids past the table
    if ($urandom_range(0, 9) == 0) t.campaign_id = 8'($urandom_range(CAMPAIGNS, 255));
    else t.campaign_id = 8'($urandom_range(0, CAMPAIGNS - 1));
    if (roll < 6) begin
      t.command  = ltattr_pkg::CMD_READ;
      t.user_key = $urandom();
    end else if (roll < 8) begin
      t.command     = ltattr_pkg::CMD_CLEAR;
      t.user_key    = $urandom();
      t.campaign_id = 8'($urandom_range(0, 255));
    end else if (roll < 9) begin
      t.command     = CMD_SPARE;
      t.user_key    = $urandom();
      t.campaign_id = 8'($urandom_range(0, 255));
    end else if (roll < 12) begin
      // out-of-order key breaks the run
      t.user_key = $urandom();
    end
    return t;
  endfunction

  // offer one transaction and hold it until accepted; the sender works in
  // bursts and drops valid for a random gap between them
  task automatic send_row(input ltattr_pkg::ltattr_in_t item);
    int gap;
    if (burst_left == 0) begin
      if (!steady_sender) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] key;
    int sent;
    int run_len;
    int pick;
    in_valid      <= 1'b0;
    in_data       <= '0;
    rst_n         <= 1'b0;
    burst_left    = 0;
    steady_sender = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // trigger before any run: key matches the reset key but no run is live yet
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h0, 1'b1, 16'd5, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h0, 1'b0, 16'd0, 8'd1));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h0, 1'b1, 16'd100, 8'd0));
    // zero value still credits
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h0, 1'b1, 16'd0, 8'd2));
    // new key, trigger with no source in its run
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h1, 1'b1, 16'd7, 8'd1));
    // the later source wins
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h1, 1'b0, 16'd0, 8'd3));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h1, 1'b0, 16'd0, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h1, 1'b1, 16'hFFFF, 8'd3));
    // bad source ids at both ends of the bad range
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h2, 1'b0, 16'd0, 8'd255));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h2, 1'b1, 16'd9, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h2, 1'b0, 16'd0, CAMPAIGNS[7:0]));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h2, 1'b1, 16'd9, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h2, 1'b0, 16'd0, 8'd2));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h2, 1'b1, 16'd1, 8'd0));
    // reads of every counter and of bad ids
    send_row(make_row(ltattr_pkg::CMD_READ, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_READ, 32'h0, 1'b0, 16'd0, 8'd1));
    send_row(make_row(ltattr_pkg::CMD_READ, 32'h0, 1'b0, 16'd0, 8'd2));
    send_row(make_row(ltattr_pkg::CMD_READ, 32'h0, 1'b0, 16'd0, 8'd3));
    send_row(make_row(ltattr_pkg::CMD_READ, 32'h0, 1'b0, 16'd0, CAMPAIGNS[7:0]));
    send_row(make_row(ltattr_pkg::CMD_READ, 32'h0, 1'b0, 16'd0, 8'd255));
    // unused command with every field at its max
    send_row(make_row(CMD_SPARE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'd255));
    // clear drops counters and run tracking, so the same key starts over
    send_row(make_row(ltattr_pkg::CMD_CLEAR, 32'h2, 1'b0, 16'd0, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_READ, 32'h0, 1'b0, 16'd0, 8'd1));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h2, 1'b1, 16'd3, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'hFFFF_FFFF, 1'b0, 16'd0, 8'd3));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'd0));
    wait_for_results();

    // one run of max-value triggers on the last campaign, sent without gaps
    // so each credit reads the counter the previous one just wrote
    steady_sender = 1'b1;
    send_row(make_row(ltattr_pkg::CMD_CLEAR, 32'h0, 1'b0, 16'd0, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h5A5A_0000, 1'b0, 16'd0,
                      CAMPAIGNS[7:0] - 8'd1));
    for (int i = 0; i < HEAVY_ROWS; i++)
      send_row(make_row(ltattr_pkg::CMD_ROW, 32'h5A5A_0000, 1'b1, 16'hFFFF, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h5A5A_0000, 1'b1, 16'd0, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_ROW, 32'h5A5A_0000, 1'b1, 16'd1, 8'd0));
    send_row(make_row(ltattr_pkg::CMD_READ, 32'h0, 1'b0, 16'd0, CAMPAIGNS[7:0] - 8'd1));
    steady_sender = 1'b0;
    wait_for_results();

    // random runs with keys mostly ascending, now and then a jump or a repeat
    key  = $urandom_range(0, 1000);
    sent = 0;
    while (sent < RANDOM_ROWS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) key = $urandom();
      else if (pick < 9) key = key + $urandom_range(1, 5000);
      run_len = $urandom_range(1, 6);
      repeat (run_len) begin
        send_row(random_row(key));
        sent++;
        if (sent % 125 == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tb_last_touch_attribution_core: clean");
    else
      $display("tb_last_touch_attribution_core: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ltattr_pkg.sv
hw/rtl/ltattr_ram.sv
hw/rtl/ltattr_front.sv
hw/rtl/ltattr_acc.sv
hw/rtl/last_touch_attribution_core.sv
dv/ltattr_checker.sv
dv/tb_last_touch_attribution_core.sv
